// ===== design/didr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// didr_pkg
// shared types and constants of the dual iir drive regulator
// ----------------------------------------------------------------------------
package didr_pkg;

	localparam int MAX_TAPS = 8;
	localparam int TAP_W = 3;
	localparam int DEF_POS_TAPS = 3;
	localparam int DEF_ANG_TAPS = 3;

	localparam logic [30:0] LIN_LIMIT_RST = 31'd1123474;
	localparam logic [30:0] ANG_LIMIT_RST = 31'd1572864;
	localparam logic [23:0] INV_SUPPLY_RST = 24'd1398101;

	localparam logic [1:0] KIND_LOAD = 2'd0;
	localparam logic [1:0] KIND_TICK = 2'd1;
	localparam logic [1:0] KIND_CLEAR = 2'd2;

	localparam logic [1:0] CFG_LIN_LIMIT = 2'd0;
	localparam logic [1:0] CFG_ANG_LIMIT = 2'd1;
	localparam logic [1:0] CFG_INV_SUPPLY = 2'd2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MAC,
		ST_CONV,
		ST_MIX,
		ST_DUTY,
		ST_OUT
	} state_t;

	// controller commands to datapath
	typedef struct packed {
		logic load;     // store coefficient from input word
		logic clear;    // zero histories
		logic start;    // latch errors
		logic mac;      // one tap step
		logic conv;     // convert, shift histories
		logic mix;      // clamp and mix
		logic duty;     // duty multiply
	} cmd_t;

endpackage

// ===== design/didr_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// didr_ctrl
// sequencer of the regulator: tap steps, conversion, mixing and output
// ----------------------------------------------------------------------------
module didr_ctrl #(
	parameter int MAX_T = didr_pkg::DEF_POS_TAPS
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic [1:0]           in_kind,
	output logic                 in_ready,
	input  logic                 out_busy,
	output logic                 out_load,
	output logic [didr_pkg::TAP_W:0] step,
	output didr_pkg::cmd_t       cmd
);
	didr_pkg::state_t state_q, state_n;
	logic [didr_pkg::TAP_W:0] step_q;
	logic acc_in;

	assign acc_in = in_valid && in_ready;
	assign step = step_q;

	always_comb begin
		state_n = state_q;
		unique case (state_q)
			didr_pkg::ST_IDLE: begin
				if (acc_in && in_kind == didr_pkg::KIND_TICK) state_n = didr_pkg::ST_MAC;
			end
			didr_pkg::ST_MAC: begin
				if (step_q == (didr_pkg::TAP_W + 1)'(MAX_T - 1)) state_n = didr_pkg::ST_CONV;
			end
			didr_pkg::ST_CONV: state_n = didr_pkg::ST_MIX;
			didr_pkg::ST_MIX: state_n = didr_pkg::ST_DUTY;
			didr_pkg::ST_DUTY: state_n = didr_pkg::ST_OUT;
			didr_pkg::ST_OUT: begin
				if (!out_busy) state_n = didr_pkg::ST_IDLE;
			end
			default: state_n = didr_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready = (state_q == didr_pkg::ST_IDLE);
		cmd = '0;
		out_load = 1'b0;
		unique case (state_q)
			didr_pkg::ST_IDLE: begin
				cmd.load = acc_in && in_kind == didr_pkg::KIND_LOAD;
				cmd.clear = acc_in && in_kind == didr_pkg::KIND_CLEAR;
				cmd.start = acc_in && in_kind == didr_pkg::KIND_TICK;
			end
			didr_pkg::ST_MAC: cmd.mac = 1'b1;
			didr_pkg::ST_CONV: cmd.conv = 1'b1;
			didr_pkg::ST_MIX: cmd.mix = 1'b1;
			didr_pkg::ST_DUTY: cmd.duty = 1'b1;
			didr_pkg::ST_OUT: out_load = !out_busy;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= didr_pkg::ST_IDLE;
			step_q <= '0;
		end else begin
			state_q <= state_n;
			if (state_q == didr_pkg::ST_MAC) step_q <= step_q + 1'b1;
			else step_q <= '0;
		end
	end
endmodule

// ===== design/didr_path.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// didr_path
// two iir filters with shared tap step, clamp, mix and duty scaling
// ----------------------------------------------------------------------------
module didr_path #(
	parameter int POS_TAPS = didr_pkg::DEF_POS_TAPS,
	parameter int ANG_TAPS = didr_pkg::DEF_ANG_TAPS
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  didr_pkg::cmd_t           cmd,
	input  logic [didr_pkg::TAP_W:0] step,
	input  logic [1:0]               coef_table,
	input  logic [2:0]               coef_tap,
	input  logic signed [31:0]       coef_value,
	input  logic signed [31:0]       pos_error,
	input  logic signed [31:0]       ang_error,
	input  logic [30:0]              lin_limit,
	input  logic [30:0]              ang_limit,
	input  logic [23:0]              inv_supply,
	output logic [15:0]              right_duty,
	output logic [15:0]              left_duty,
	output logic                     right_forward,
	output logic                     left_forward
);
	localparam int MT = didr_pkg::MAX_TAPS;
	localparam int TAP_W_L = didr_pkg::TAP_W;
	localparam logic signed [63:0] AMAX = 64'sh7FFF_FFFF_FFFF_FFFF;
	localparam logic signed [63:0] AMIN = -AMAX;

	logic signed [31:0] coef_q [4][MT];
	logic signed [31:0] peh_q [MT], pyh_q [MT], aeh_q [MT], ayh_q [MT];
	logic signed [31:0] pe_q, ae_q, pv_q, av_q;
	logic signed [63:0] pacc_q, aacc_q;
	logic signed [32:0] right_q, left_q;
	logic [15:0] rd_q, ld_q;
	logic [TAP_W_L-1:0] ti;

	assign ti = step[TAP_W_L-1:0];

	function automatic logic signed [63:0] sadd(input logic signed [63:0] a,
			input logic signed [64:0] b);
		logic signed [65:0] s;
		s = 66'(a) + 66'(b);
		if (s > 66'(AMAX)) return AMAX;
		if (s < 66'(AMIN)) return AMIN;
		return s[63:0];
	endfunction

	function automatic logic signed [31:0] to_q16(input logic signed [63:0] a);
		logic signed [39:0] q;
		q = a[63:24];
		if (q > 40'sh007FFFFFFF) return 32'sh7FFFFFFF;
		if (q < -40'sh0080000000) return 32'sh80000000;
		return q[31:0];
	endfunction

	function automatic logic signed [31:0] clampv(input logic signed [31:0] v,
			input logic [30:0] l);
		logic signed [32:0] ls;
		ls = {2'b00, l};
		if (33'(v) > ls) return 32'(ls);
		if (33'(v) < -ls) return 32'(-ls);
		return v;
	endfunction

	function automatic logic [15:0] dutyf(input logic signed [32:0] c,
			input logic [23:0] s);
		logic [32:0] m;
		logic [56:0] p;
		m = c[32] ? 33'(-c) : 33'(c);
		p = 57'(m) * 57'(s);
		if (p[56:24] > 33'd65535) return 16'hFFFF;
		return p[39:24];
	endfunction

	// per-step terms: one 32x32 product at step zero, else the difference of two
	logic signed [64:0] pterm, aterm;
	always_comb begin
		pterm = '0;
		aterm = '0;
		if (step == '0) begin
			pterm = 65'(coef_q[0][0] * pe_q);
			aterm = 65'(coef_q[2][0] * ae_q);
		end else begin
			pterm = 65'(coef_q[0][ti] * peh_q[ti - 1'b1])
				- 65'(coef_q[1][ti] * pyh_q[ti - 1'b1]);
			aterm = 65'(coef_q[2][ti] * aeh_q[ti - 1'b1])
				- 65'(coef_q[3][ti] * ayh_q[ti - 1'b1]);
		end
	end

	// past step zero, saturate after each of the two tap products
	logic signed [63:0] pff, aff, pnext, anext;
	always_comb begin
		pff = pacc_q;
		aff = aacc_q;
		pnext = pacc_q;
		anext = aacc_q;
		if (step == '0) begin
			pnext = 64'(pterm);
			anext = 64'(aterm);
		end else begin
			pff = sadd(pacc_q, 65'(coef_q[0][ti] * peh_q[ti - 1'b1]));
			aff = sadd(aacc_q, 65'(coef_q[2][ti] * aeh_q[ti - 1'b1]));
			pnext = sadd(pff, -65'(coef_q[1][ti] * pyh_q[ti - 1'b1]));
			anext = sadd(aff, -65'(coef_q[3][ti] * ayh_q[ti - 1'b1]));
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			pe_q <= pos_error;
			ae_q <= ang_error;
		end
		if (cmd.mac) begin
			if (32'(step) < POS_TAPS) pacc_q <= pnext;
			if (32'(step) < ANG_TAPS) aacc_q <= anext;
		end
		if (cmd.conv) begin
			pv_q <= to_q16(pacc_q);
			av_q <= to_q16(aacc_q);
		end
		if (cmd.mix) begin
			right_q <= 33'(clampv(pv_q, lin_limit)) + 33'(clampv(av_q, ang_limit));
			left_q <= 33'(clampv(pv_q, lin_limit)) - 33'(clampv(av_q, ang_limit));
		end
		if (cmd.duty) begin
			rd_q <= dutyf(right_q, inv_supply);
			ld_q <= dutyf(left_q, inv_supply);
		end
	end

	// coefficient tables, zero after reset, loads beyond the tap count dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int t = 0; t < 4; t++) begin
				for (int i = 0; i < MT; i++) coef_q[t][i] <= '0;
			end
		end else if (cmd.load) begin
			if (coef_table < 2'd2) begin
				if (32'(coef_tap) < POS_TAPS) coef_q[coef_table][coef_tap] <= coef_value;
			end else if (32'(coef_tap) < ANG_TAPS) begin
				coef_q[coef_table][coef_tap] <= coef_value;
			end
		end
	end

	// histories zero on reset and clear, shifted on conversion
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MT; i++) begin
				peh_q[i] <= '0; pyh_q[i] <= '0; aeh_q[i] <= '0; ayh_q[i] <= '0;
			end
		end else if (cmd.clear) begin
			for (int i = 0; i < MT; i++) begin
				peh_q[i] <= '0; pyh_q[i] <= '0; aeh_q[i] <= '0; ayh_q[i] <= '0;
			end
		end else if (cmd.conv) begin
			for (int i = 1; i < MT; i++) begin
				peh_q[i] <= peh_q[i-1]; pyh_q[i] <= pyh_q[i-1];
				aeh_q[i] <= aeh_q[i-1]; ayh_q[i] <= ayh_q[i-1];
			end
			peh_q[0] <= pe_q;
			pyh_q[0] <= to_q16(pacc_q);
			aeh_q[0] <= ae_q;
			ayh_q[0] <= to_q16(aacc_q);
		end
	end

	assign right_duty = rd_q;
	assign left_duty = ld_q;
	assign right_forward = !right_q[32];
	assign left_forward = !left_q[32];
endmodule

// ===== design/dual_iir_drive_regulator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dual_iir_drive_regulator
// two iir regulators feeding a differential drive mixer
// ----------------------------------------------------------------------------
// usage:
//   s_axis carries load, tick and clear words; load and clear give no
//   result. a tick runs a shared tap step per cycle over max(POS_TAPS,
//   ANG_TAPS) taps, then convert, mix and duty stages, and loads the
//   output register. one tick is in flight at a time; the next word is
//   taken once that result is loaded, which waits while m_axis stalls.
//   m_axis holds a result until taken; a stalled receiver holds the block.
//   cfg writes registers; the user must keep them to times the block is
//   idle, which the block itself does not enforce.
//   reset clears histories, coefficients and registers to their defaults.
// ----------------------------------------------------------------------------
module dual_iir_drive_regulator #(
	parameter int POS_TAPS = didr_pkg::DEF_POS_TAPS,
	parameter int ANG_TAPS = didr_pkg::DEF_ANG_TAPS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// coef_tap[2:0], coef_value[34:3], pos_error[66:35], ang_error[98:67]
	input  logic [103:0] s_axis_tdata,
	// kind[1:0], coef_table[3:2]
	input  logic [3:0]  s_axis_tuser,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// right_duty[15:0], left_duty[31:16]
	output logic [31:0] m_axis_tdata,
	// right_forward[0], left_forward[1]
	output logic [1:0]  m_axis_tuser,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data
);
	localparam int MAXT = (POS_TAPS > ANG_TAPS) ? POS_TAPS : ANG_TAPS;

	didr_pkg::cmd_t cmd;
	logic [didr_pkg::TAP_W:0] step;
	logic out_load;
	logic [30:0] lin_q, ang_q;
	logic [23:0] inv_q;
	logic [15:0] rd, ld;
	logic rf, lf;
	logic [31:0] od_q;
	logic [1:0] ou_q;
	logic ov_q;

	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lin_q <= didr_pkg::LIN_LIMIT_RST;
			ang_q <= didr_pkg::ANG_LIMIT_RST;
			inv_q <= didr_pkg::INV_SUPPLY_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				didr_pkg::CFG_LIN_LIMIT: lin_q <= cfg_data[30:0];
				didr_pkg::CFG_ANG_LIMIT: ang_q <= cfg_data[30:0];
				didr_pkg::CFG_INV_SUPPLY: inv_q <= cfg_data[23:0];
				default: ;
			endcase
		end
	end

	didr_ctrl #(.MAX_T(MAXT)) u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(s_axis_tvalid),
		.in_kind(s_axis_tuser[1:0]), .in_ready(s_axis_tready),
		.out_busy(ov_q && !m_axis_tready), .out_load(out_load),
		.step(step), .cmd(cmd)
	);

	didr_path #(.POS_TAPS(POS_TAPS), .ANG_TAPS(ANG_TAPS)) u_path (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .step(step),
		.coef_table(s_axis_tuser[3:2]), .coef_tap(s_axis_tdata[2:0]),
		.coef_value(s_axis_tdata[34:3]), .pos_error(s_axis_tdata[66:35]),
		.ang_error(s_axis_tdata[98:67]), .lin_limit(lin_q), .ang_limit(ang_q),
		.inv_supply(inv_q), .right_duty(rd), .left_duty(ld),
		.right_forward(rf), .left_forward(lf)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) ov_q <= 1'b0;
		else if (out_load) ov_q <= 1'b1;
		else if (m_axis_tready) ov_q <= 1'b0;
	end
	always_ff @(posedge clk) begin
		if (out_load) begin
			od_q <= {ld, rd};
			ou_q <= {lf, rf};
		end
	end

	assign m_axis_tvalid = ov_q;
	assign m_axis_tdata = od_q;
	assign m_axis_tuser = ou_q;
endmodule
